/* rtl/p2hc_pkg.sv */
`default_nettype none
package p2hc_pkg;

    // field widths
    localparam int IN_W       = 16;
    localparam int HEX_Q_W    = 16;
    localparam int HEX_R_W    = 16;
    localparam int HEX_S_W    = 17;
    localparam int IN_TDATA_W = 32;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_PAD_W  = OUT_TDATA_W - HEX_Q_W - HEX_R_W - HEX_S_W;

    // cell size register, unsigned q8.8
    localparam int SIZE_W = 16;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 16'd256;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd2560;
    // size is at least 2^SIZE_SKIP, so the top quotient bits are always zero
    localparam int SIZE_SKIP = 8;

    // q1.16 constants
    localparam int K_W = 17;
    localparam logic signed [K_W-1:0] K_TWO_THIRDS  = 17'sd43691;
    localparam logic signed [K_W-1:0] K_ONE_THIRD   = 17'sd21845;
    localparam logic signed [K_W-1:0] K_SQRT3_THIRD = 17'sd37837;

    // products and numerators in q.16 pixel units
    localparam int PROD_W = K_W + IN_W;
    // magnitude of any numerator stays below 2^31
    localparam int MAG_W  = 31;

endpackage
`default_nettype wire

/* rtl/pixel_to_hex_cell_unit.sv */
`default_nettype none
// channel      | direction | fields (lowest bit first)
// -------------+-----------+-----------------------------------------------
// s_axis       | in        | tdata: point_x[15:0], point_y[31:16]
// m_axis       | out       | tdata: hex_q[15:0], hex_r[31:16], hex_s[48:32]
// cfg          | in        | i_cfg_we / i_cfg_wdata: cell_size, q8.8
//
// one transaction per cycle when not stalled; FRACTION_BITS + 24 register stages
// an accepted transaction runs through stages a to d, the dividers, then e to i
// most stages sit in the two parallel dividers, FRACTION_BITS + 15 one-bit stages each
// reset clears the stage valid bits and loads cell_size with 10.0
// a stall on m_axis freezes every stage at once, s_axis_tready follows it
// cell_size below 1.0 is stored as 1.0
module pixel_to_hex_cell_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration
    input  wire logic                                   i_cfg_we,
    input  wire logic [p2hc_pkg::SIZE_W-1:0]            i_cfg_wdata,
    // input stream
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // point_x [15:0], point_y [31:16]
    input  wire logic [p2hc_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // output stream
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // hex_q [15:0], hex_r [31:16], hex_s [48:32], zero fill above
    output logic      [p2hc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

    localparam int FB     = FRACTION_BITS;
    localparam int MAG_W  = p2hc_pkg::MAG_W;
    localparam int PROD_W = p2hc_pkg::PROD_W;
    localparam int IN_W   = p2hc_pkg::IN_W;
    // quotient width, see divider
    localparam int QW     = MAG_W + FB - 2 * p2hc_pkg::SIZE_SKIP;
    // rounded integer magnitudes of q and r, and of s
    localparam int INT_W  = QW + 1 - FB;
    localparam int INTS_W = QW + 2 - FB;
    // width for the rebuild sum
    localparam int RB_W   = INTS_W + 2;
    // entry, multiply, sum, magnitude, divider, then five post stages
    localparam int N_STG  = QW + 9;

    localparam logic [QW:0]   HALF_Q = (QW+1)'(1) << (FB - 1);
    localparam logic [QW+1:0] HALF_S = (QW+2)'(1) << (FB - 1);

    // control
    logic             w_adv;
    logic [N_STG-1:0] r_vld;
    logic [p2hc_pkg::SIZE_W-1:0] r_size;

    // stage a: captured point
    logic signed [IN_W-1:0] r_a_x, r_a_y;
    // stage b: products
    logic signed [PROD_W-1:0] r_b_pq, r_b_prx, r_b_pry;
    // stage c: numerators
    logic signed [PROD_W-1:0] r_c_numq, r_c_numr;
    // stage d: magnitudes and signs
    logic [MAG_W-1:0] r_d_mq, r_d_mr;
    logic             r_d_nq, r_d_nr;
    logic signed [PROD_W-1:0] w_d_aq, w_d_ar;
    // divider outputs
    logic [QW-1:0] w_quo_q, w_quo_r;
    logic          w_neg_q, w_neg_r;
    // stage e: signed fractional q and r
    logic signed [QW:0] r_e_fq, r_e_fr;
    logic [QW-1:0]      r_e_mq, r_e_mr;
    logic               r_e_nq, r_e_nr;
    // stage f: fractional s, rounded q and r
    logic signed [QW+1:0] r_f_fs, w_f_fs;
    logic [QW:0]          w_f_sumq, w_f_sumr;
    logic [INT_W-1:0]     r_f_iq, r_f_ir;
    logic [FB-1:0]        r_f_eq, r_f_er;
    logic                 r_f_nq, r_f_nr;
    // stage g: magnitude of s
    logic [QW:0]          r_g_ms;
    logic                 r_g_ns;
    logic [INT_W-1:0]     r_g_iq, r_g_ir;
    logic [FB-1:0]        r_g_eq, r_g_er;
    logic                 r_g_nq, r_g_nr;
    logic signed [QW+1:0] w_g_as;
    // stage h: rounded s, signed q and r
    logic [QW+1:0]         w_h_sums;
    logic [INTS_W-1:0]     r_h_is;
    logic                  r_h_ns;
    logic [FB-1:0]         r_h_eq, r_h_er, r_h_es;
    logic signed [INT_W:0] r_h_sq, r_h_sr, w_h_pq, w_h_pr;
    // stage i: output register
    logic signed [INTS_W:0] w_i_ps, w_i_ss;
    logic signed [RB_W-1:0] w_i_xq, w_i_xr, w_i_xs;
    logic signed [RB_W-1:0] n_i_q, n_i_r, n_i_s;
    logic [p2hc_pkg::HEX_Q_W-1:0] r_i_q;
    logic [p2hc_pkg::HEX_R_W-1:0] r_i_r;
    logic [p2hc_pkg::HEX_S_W-1:0] r_i_s;

    // whole pipeline moves unless a finished result is held
    assign w_adv         = !r_vld[N_STG-1] || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = r_vld[N_STG-1];
    assign m_axis_tdata  = {p2hc_pkg::OUT_PAD_W'(0), r_i_s, r_i_r, r_i_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[N_STG-2:0], s_axis_tvalid};
        end
    end

    // cell size, clamped to 1.0 on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= p2hc_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            r_size <= (i_cfg_wdata < p2hc_pkg::SIZE_MIN) ? p2hc_pkg::SIZE_MIN : i_cfg_wdata;
        end
    end

    // magnitudes for the dividers
    assign w_d_aq = r_c_numq[PROD_W-1] ? -r_c_numq : r_c_numq;
    assign w_d_ar = r_c_numr[PROD_W-1] ? -r_c_numr : r_c_numr;

    p2hc_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div_q (
        .i_clk     (i_clk),
        .i_en      (w_adv),
        .i_mag     (r_d_mq),
        .i_neg     (r_d_nq),
        .i_divisor (r_size),
        .o_quo     (w_quo_q),
        .o_neg     (w_neg_q)
    );

    p2hc_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div_r (
        .i_clk     (i_clk),
        .i_en      (w_adv),
        .i_mag     (r_d_mr),
        .i_neg     (r_d_nr),
        .i_divisor (r_size),
        .o_quo     (w_quo_r),
        .o_neg     (w_neg_r)
    );

    // fractional s is exactly -q - r
    assign w_f_fs   = -(QW+2)'(r_e_fq) - (QW+2)'(r_e_fr);
    // round half away from zero on the magnitude
    assign w_f_sumq = {1'b0, r_e_mq} + HALF_Q;
    assign w_f_sumr = {1'b0, r_e_mr} + HALF_Q;

    assign w_g_as   = r_f_fs[QW+1] ? -r_f_fs : r_f_fs;

    assign w_h_sums = {1'b0, r_g_ms} + HALF_S;
    assign w_h_pq   = signed'({1'b0, r_g_iq});
    assign w_h_pr   = signed'({1'b0, r_g_ir});

    assign w_i_ps   = signed'({1'b0, r_h_is});
    assign w_i_ss   = r_h_ns ? -w_i_ps : w_i_ps;
    assign w_i_xq   = RB_W'(r_h_sq);
    assign w_i_xr   = RB_W'(r_h_sr);
    assign w_i_xs   = RB_W'(w_i_ss);

    // the coordinate with the largest rounding error is rebuilt; on a tie s wins over r, r over q
    always_comb begin
        n_i_q = w_i_xq;
        n_i_r = w_i_xr;
        n_i_s = w_i_xs;
        priority if (r_h_eq > r_h_er && r_h_eq > r_h_es) begin
            n_i_q = -w_i_xr - w_i_xs;
        end else if (r_h_er > r_h_es) begin
            n_i_r = -w_i_xq - w_i_xs;
        end else begin
            n_i_s = -w_i_xq - w_i_xr;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // a: capture
            r_a_x    <= s_axis_tdata[IN_W-1:0];
            r_a_y    <= s_axis_tdata[2*IN_W-1:IN_W];
            // b: constant products
            r_b_pq   <= p2hc_pkg::K_TWO_THIRDS * r_a_x;
            r_b_prx  <= p2hc_pkg::K_ONE_THIRD * r_a_x;
            r_b_pry  <= p2hc_pkg::K_SQRT3_THIRD * r_a_y;
            // c: numerators
            r_c_numq <= r_b_pq;
            r_c_numr <= r_b_pry - r_b_prx;
            // d: sign and magnitude
            r_d_mq   <= w_d_aq[MAG_W-1:0];
            r_d_mr   <= w_d_ar[MAG_W-1:0];
            r_d_nq   <= r_c_numq[PROD_W-1];
            r_d_nr   <= r_c_numr[PROD_W-1];
            // e: signed quotients
            r_e_mq   <= w_quo_q;
            r_e_mr   <= w_quo_r;
            r_e_nq   <= w_neg_q;
            r_e_nr   <= w_neg_r;
            r_e_fq   <= w_neg_q ? -signed'({1'b0, w_quo_q}) : signed'({1'b0, w_quo_q});
            r_e_fr   <= w_neg_r ? -signed'({1'b0, w_quo_r}) : signed'({1'b0, w_quo_r});
            // f: s, rounding of q and r; error is the distance to the nearer integer
            r_f_fs   <= w_f_fs;
            r_f_iq   <= w_f_sumq[QW:FB];
            r_f_ir   <= w_f_sumr[QW:FB];
            r_f_eq   <= r_e_mq[FB-1] ? -r_e_mq[FB-1:0] : r_e_mq[FB-1:0];
            r_f_er   <= r_e_mr[FB-1] ? -r_e_mr[FB-1:0] : r_e_mr[FB-1:0];
            r_f_nq   <= r_e_nq;
            r_f_nr   <= r_e_nr;
            // g: magnitude of s
            r_g_ms   <= w_g_as[QW:0];
            r_g_ns   <= r_f_fs[QW+1];
            r_g_iq   <= r_f_iq;
            r_g_ir   <= r_f_ir;
            r_g_eq   <= r_f_eq;
            r_g_er   <= r_f_er;
            r_g_nq   <= r_f_nq;
            r_g_nr   <= r_f_nr;
            // h: rounding of s, signs back on q and r
            r_h_is   <= w_h_sums[QW+1:FB];
            r_h_es   <= r_g_ms[FB-1] ? -r_g_ms[FB-1:0] : r_g_ms[FB-1:0];
            r_h_ns   <= r_g_ns;
            r_h_eq   <= r_g_eq;
            r_h_er   <= r_g_er;
            r_h_sq   <= r_g_nq ? -w_h_pq : w_h_pq;
            r_h_sr   <= r_g_nr ? -w_h_pr : w_h_pr;
            // i: rebuild and output register
            r_i_q    <= n_i_q[p2hc_pkg::HEX_Q_W-1:0];
            r_i_r    <= n_i_r[p2hc_pkg::HEX_R_W-1:0];
            r_i_s    <= n_i_s[p2hc_pkg::HEX_S_W-1:0];
        end
    end

    // a stall freezes the stage valid bits
    a_stall_freeze : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("stage valid bits moved during a stall");

    // an accepted transaction enters the first stage
    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted transaction lost at entry");

    // cube coordinates sum to zero whenever m_axis_tvalid is high
    a_cube_sum : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (p2hc_pkg::HEX_S_W'(signed'(r_i_q)) + p2hc_pkg::HEX_S_W'(signed'(r_i_r))
                           + r_i_s) == p2hc_pkg::HEX_S_W'(0))
        else $error("q + r + s is not zero");

    // divisor never drops below 1.0
    a_size_floor : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size >= p2hc_pkg::SIZE_MIN)
        else $error("cell size below minimum");

endmodule
`default_nettype wire

/* rtl/p2hc_div.sv */
`default_nettype none
// pipelined restoring divider, one quotient bit per stage
module p2hc_div #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_en,
    input  wire logic [p2hc_pkg::MAG_W-1:0]                   i_mag,
    input  wire logic                                         i_neg,
    input  wire logic [p2hc_pkg::SIZE_W-1:0]                  i_divisor,
    output logic      [p2hc_pkg::MAG_W+FRACTION_BITS-17:0]    o_quo,
    output logic                                              o_neg
);

    localparam int SW = p2hc_pkg::SIZE_W;
    localparam int DW = p2hc_pkg::MAG_W + FRACTION_BITS - p2hc_pkg::SIZE_SKIP;
    localparam int QW = DW - p2hc_pkg::SIZE_SKIP;

    logic [DW-1:0] w_dividend;

    logic [SW-1:0] w_rem_in  [QW];
    logic [QW-1:0] w_work_in [QW];
    logic          w_neg_in  [QW];

    logic [SW-1:0] r_rem  [QW];
    logic [SW-1:0] n_rem  [QW];
    logic [QW-1:0] r_work [QW];
    logic [QW-1:0] n_work [QW];
    logic          r_neg  [QW];

    assign w_dividend = DW'(i_mag) << (FRACTION_BITS - p2hc_pkg::SIZE_SKIP);

    // top bits are below the divisor, so they seed the remainder directly
    assign w_rem_in[0]  = SW'(w_dividend[DW-1 -: p2hc_pkg::SIZE_SKIP]);
    assign w_work_in[0] = w_dividend[QW-1:0];
    assign w_neg_in[0]  = i_neg;

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [SW:0] w_trial;
        logic [SW:0] w_diff;

        if (g > 0) begin : g_link
            assign w_rem_in[g]  = r_rem[g-1];
            assign w_work_in[g] = r_work[g-1];
            assign w_neg_in[g]  = r_neg[g-1];
        end

        always_comb begin
            w_trial   = {w_rem_in[g], w_work_in[g][QW-1]};
            w_diff    = w_trial - {1'b0, i_divisor};
            n_rem[g]  = w_diff[SW] ? w_trial[SW-1:0] : w_diff[SW-1:0];
            n_work[g] = {w_work_in[g][QW-2:0], ~w_diff[SW]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem[g];
                r_work[g] <= n_work[g];
                r_neg[g]  <= w_neg_in[g];
            end
        end
    end

    assign o_quo = r_work[QW-1];
    assign o_neg = r_neg[QW-1];

endmodule
`default_nettype wire
